@@ design/stereo_lfo_pan_gain_modulator_macros.svh @@
// assertion macros for the stereo pan and gain modulator checker
// no dependencies; included by the checker file only
`ifndef STEREO_LFO_PAN_GAIN_MODULATOR_MACROS_SVH
`define STEREO_LFO_PAN_GAIN_MODULATOR_MACROS_SVH

// same-cycle implication, off during reset
`define SLPGM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slpgm check failed");

// next-cycle implication, off during reset
`define SLPGM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slpgm check failed");

// what must hold in the cycle after each reset cycle
`define SLPGM_ASSERT_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("slpgm check failed");

`endif

@@ design/slpgm_pkg.sv @@
// shared types, constants and coefficient tables of the stereo pan and gain modulator
// no dependencies; used by the top level and its checker
package slpgm_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int SINE_IDX_BITS   = $clog2(SINE_TABLE_SIZE);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;

  localparam int CFG_INDEX_BITS = 4;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_ENABLED          = cfg_index_t'(0);
  localparam cfg_index_t REG_PHASE_STEP       = cfg_index_t'(1);
  localparam cfg_index_t REG_PAN_DEPTH        = cfg_index_t'(2);
  localparam cfg_index_t REG_GAIN_DEPTH       = cfg_index_t'(3);
  localparam cfg_index_t REG_FADE_STEP        = cfg_index_t'(4);
  localparam cfg_index_t REG_ATTACK_COEF      = cfg_index_t'(5);
  localparam cfg_index_t REG_RELEASE_COEF     = cfg_index_t'(6);
  localparam cfg_index_t REG_GAIN_PHASE_START = cfg_index_t'(7);

  localparam logic [31:0] PHASE_KEEP =
    ~((32'd1 << (32 - SINE_IDX_BITS)) - 32'd1);
  localparam logic [31:0] GAIN_PHASE_RESET = 32'd341782638;

  localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
  localparam logic [31:0] PAN_GAIN_MIN = 32'd644245094;
  localparam logic [31:0] PAN_GAIN_MAX = 32'd1503238554;
  localparam logic [31:0] TANH_ARG_Q24 = 32'd106499388;
  localparam logic [31:0] DIV10_MAGIC  = 32'd3435973837;

  localparam logic [16:0] E16_CAP  = 17'd45875;
  localparam logic [16:0] TF_ONE   = 17'd65536;
  localparam logic [24:0] FADE_ONE = 25'h100_0000;

  localparam logic [33:0] SAT_LIM = 34'(2 ** (SAMPLE_BITS - 1));
  localparam sample_t     SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t     SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd1686629713;
      3'd1:    c = 32'd693598668;
      3'd2:    c = 32'd85569306;
      3'd3:    c = 32'd5026995;
      3'd4:    c = 32'd172272;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] exp2_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd1073741824;
      3'd1:    c = 32'd744261118;
      3'd2:    c = 32'd257941248;
      3'd3:    c = 32'd59597083;
      3'd4:    c = 32'd10327388;
      3'd5:    c = 32'd1431680;
      3'd6:    c = 32'd165394;
      default: c = 32'd16378;
    endcase
    return c;
  endfunction

endpackage

@@ design/stereo_lfo_pan_gain_modulator.sv @@
// one sample pair in flight: a new pair is taken only once the last result is registered
// the work is done by one registered 32x32 multiplier, shared over 31 products, and a
// restoring divider for the 31-bit tanh quotient
// sync reset clears sequencer, config and modulation state, gain phase loads 341782638
// uses slpgm_pkg
module stereo_lfo_pan_gain_modulator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  slpgm_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  slpgm_pkg::sample_t   left_in,
  input  slpgm_pkg::sample_t   right_in,
  output logic                 result_valid,
  input  logic                 result_ready,
  output slpgm_pkg::sample_t   left_out,
  output slpgm_pkg::sample_t   right_out
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef logic [4:0] op_t;

  localparam op_t OP_ENV      = 5'd0;
  localparam op_t OP_K        = 5'd1;
  localparam op_t OP_PAN_SQ   = 5'd2;
  localparam op_t OP_PAN_P3   = 5'd3;
  localparam op_t OP_PAN_P0   = 5'd6;
  localparam op_t OP_PAN_S    = 5'd7;
  localparam op_t OP_PAN_D    = 5'd8;
  localparam op_t OP_PAN_K    = 5'd9;
  localparam op_t OP_GAIN_SQ  = 5'd10;
  localparam op_t OP_GAIN_P3  = 5'd11;
  localparam op_t OP_GAIN_P0  = 5'd14;
  localparam op_t OP_GAIN_S   = 5'd15;
  localparam op_t OP_GAIN_D   = 5'd16;
  localparam op_t OP_GAIN_K   = 5'd17;
  localparam op_t OP_TANH_Z   = 5'd18;
  localparam op_t OP_EXP_6    = 5'd19;
  localparam op_t OP_EXP_0    = 5'd25;
  localparam op_t OP_TH10     = 5'd26;
  localparam op_t OP_GL       = 5'd27;
  localparam op_t OP_GR       = 5'd28;
  localparam op_t OP_OL       = 5'd29;
  localparam op_t OP_OR       = 5'd30;

  localparam logic [4:0] DIV_LAST = 5'd30;

  state_t state;
  op_t    op;
  logic   wb;
  logic [4:0] div_cnt;

  logic        enabled;
  logic [23:0] phase_step;
  logic [15:0] pan_depth, gain_depth, fade_step, attack_coef, release_coef;

  logic [31:0]             pan_phase, gain_phase;
  slpgm_pkg::mag_t         env;
  logic [24:0]             fade;

  slpgm_pkg::mag_t    mag_l, mag_r;
  logic               neg_l, neg_r;
  logic [16:0]        k;
  logic [31:0]        acc, t2, lg, rg;
  logic [29:0]        fexp;
  logic [3:0]         nexp;
  logic [31:0]        rem, dvs;
  logic [30:0]        quo;
  slpgm_pkg::sample_t res_l, res_r;
  logic [63:0]        prod;

  logic               in_xfer;
  slpgm_pkg::mag_t    lvl, env_diff, env_step;
  logic               rise;
  logic [slpgm_pkg::SAMPLE_BITS+16:0] e16_wide;
  logic [16:0]        tf;
  logic               sin_gain, sin_neg;
  logic [31:0]        sin_phase, t_val;
  logic [4:0]         sin_k, exp_k;
  logic [33:0]        prod_q30;
  logic [31:0]        horner_sin, horner_exp, exp_shift, e_val;
  logic [31:0]        pan_m, pan_up, pan_dn;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic [24:0]        fade_sum;
  logic [31:0]        mul_a, mul_b;

  function automatic logic [31:0] pan_clamp(input logic [31:0] v);
    logic [31:0] r;
    if (v < slpgm_pkg::PAN_GAIN_MIN) begin
      r = slpgm_pkg::PAN_GAIN_MIN;
    end else if (v > slpgm_pkg::PAN_GAIN_MAX) begin
      r = slpgm_pkg::PAN_GAIN_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic slpgm_pkg::sample_t sat_out(input logic neg, input logic [33:0] mag);
    slpgm_pkg::sample_t r;
    if (!neg) begin
      r = (mag >= slpgm_pkg::SAT_LIM) ? slpgm_pkg::SAT_MAX
                                      : slpgm_pkg::sample_t'(mag[slpgm_pkg::SAMPLE_BITS-1:0]);
    end else begin
      r = (mag >= slpgm_pkg::SAT_LIM) ? slpgm_pkg::SAT_MIN
                                      : slpgm_pkg::sample_t'(~mag[slpgm_pkg::SAMPLE_BITS-1:0]
                                                             + 1'b1);
    end
    return r;
  endfunction

  assign cfg_ready    = (state == S_IDLE);
  assign sample_ready = (state == S_IDLE);
  assign in_xfer      = sample_valid && sample_ready;

  // envelope and transient factor
  assign lvl      = slpgm_pkg::mag_t'(({1'b0, mag_l} + {1'b0, mag_r}) >> 1);
  assign rise     = lvl > env;
  assign env_diff = rise ? lvl - env : env - lvl;
  assign env_step = slpgm_pkg::mag_t'(prod >> 16);
  assign e16_wide = {env, 17'b0} >> (slpgm_pkg::SAMPLE_BITS - 1);
  assign tf = slpgm_pkg::TF_ONE -
              ((e16_wide > {{slpgm_pkg::SAMPLE_BITS{1'b0}}, slpgm_pkg::E16_CAP})
               ? slpgm_pkg::E16_CAP : e16_wide[16:0]);
  assign fade_sum = fade + 25'(fade_step);

  // quantized sine argument
  assign sin_gain  = (op >= OP_GAIN_SQ);
  assign sin_phase = (sin_gain ? gain_phase : pan_phase) & slpgm_pkg::PHASE_KEEP;
  assign sin_neg   = sin_phase[31];
  assign t_val     = sin_phase[30] ? slpgm_pkg::Q30_ONE - {2'b0, sin_phase[29:0]}
                                   : {2'b0, sin_phase[29:0]};

  assign prod_q30   = prod[63:30];
  assign sin_k      = sin_gain ? OP_GAIN_P0 - op : OP_PAN_P0 - op;
  assign exp_k      = OP_EXP_0 - op;
  assign horner_sin = slpgm_pkg::sin_coef(sin_k[2:0]) - prod_q30[31:0];
  assign horner_exp = slpgm_pkg::exp2_coef(exp_k[2:0]) - prod_q30[31:0];
  assign exp_shift  = horner_exp >> nexp;
  assign e_val      = (exp_shift > slpgm_pkg::Q30_ONE) ? slpgm_pkg::Q30_ONE : exp_shift;

  assign pan_m  = prod[47:16];
  assign pan_up = slpgm_pkg::Q30_ONE + pan_m;
  assign pan_dn = slpgm_pkg::Q30_ONE - pan_m;

  // restoring divider, first step compares without shifting
  assign rem_sh = (div_cnt == 5'd0) ? {1'b0, rem} : {rem, 1'b0};
  assign div_ge = rem_sh >= {1'b0, dvs};

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (op) inside
      OP_ENV: begin
        mul_a = 32'(env_diff);
        mul_b = {16'd0, rise ? attack_coef : release_coef};
      end
      OP_K: begin
        mul_a = 32'(fade);
        mul_b = 32'(tf);
      end
      OP_PAN_SQ, OP_GAIN_SQ: begin
        mul_a = t_val;
        mul_b = t_val;
      end
      [OP_PAN_P3:OP_PAN_P0], [OP_GAIN_P3:OP_GAIN_P0]: begin
        mul_a = acc;
        mul_b = t2;
      end
      OP_PAN_S, OP_GAIN_S: begin
        mul_a = acc;
        mul_b = t_val;
      end
      OP_PAN_D: begin
        mul_a = acc;
        mul_b = {16'd0, pan_depth};
      end
      OP_GAIN_D: begin
        mul_a = acc;
        mul_b = {16'd0, gain_depth};
      end
      OP_PAN_K, OP_GAIN_K: begin
        mul_a = acc;
        mul_b = 32'(k);
      end
      OP_TANH_Z: begin
        mul_a = acc;
        mul_b = slpgm_pkg::TANH_ARG_Q24;
      end
      [OP_EXP_6:OP_EXP_0]: begin
        mul_a = acc;
        mul_b = {2'b0, fexp};
      end
      OP_TH10: begin
        mul_a = {1'b0, quo};
        mul_b = slpgm_pkg::DIV10_MAGIC;
      end
      OP_GL: begin
        mul_a = lg;
        mul_b = acc;
      end
      OP_GR: begin
        mul_a = rg;
        mul_b = acc;
      end
      OP_OL: begin
        mul_a = 32'(mag_l);
        mul_b = lg;
      end
      OP_OR: begin
        mul_a = 32'(mag_r);
        mul_b = rg;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // sequencer, configuration and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_ENV;
      wb           <= 1'b0;
      div_cnt      <= 5'd0;
      result_valid <= 1'b0;
      enabled      <= 1'b0;
      phase_step   <= 24'd0;
      pan_depth    <= 16'd0;
      gain_depth   <= 16'd0;
      fade_step    <= 16'd0;
      attack_coef  <= 16'd0;
      release_coef <= 16'd0;
      pan_phase    <= 32'd0;
      gain_phase   <= slpgm_pkg::GAIN_PHASE_RESET;
      env          <= '0;
      fade         <= 25'd0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op      <= OP_ENV;
            wb      <= 1'b0;
            state   <= enabled ? S_CALC : S_DONE;
          end
        end
        S_CALC: begin
          wb <= ~wb;
          if (wb) begin
            case (op)
              OP_ENV: begin
                env <= rise ? env + env_step : env - env_step;
                if (fade < slpgm_pkg::FADE_ONE) begin
                  fade <= (fade_sum > slpgm_pkg::FADE_ONE) ? slpgm_pkg::FADE_ONE : fade_sum;
                end
                op <= op + 5'd1;
              end
              OP_EXP_0: begin
                div_cnt <= 5'd0;
                state   <= S_DIV;
              end
              OP_OR: begin
                pan_phase  <= pan_phase + {8'd0, phase_step};
                gain_phase <= gain_phase + {8'd0, phase_step};
                state      <= S_DONE;
              end
              default: begin
                op <= op + 5'd1;
              end
            endcase
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == DIV_LAST) begin
            op    <= OP_TH10;
            wb    <= 1'b0;
            state <= S_CALC;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          slpgm_pkg::REG_ENABLED:          enabled      <= cfg_data[0];
          slpgm_pkg::REG_PHASE_STEP:       phase_step   <= cfg_data[23:0];
          slpgm_pkg::REG_PAN_DEPTH:        pan_depth    <= cfg_data[15:0];
          slpgm_pkg::REG_GAIN_DEPTH:       gain_depth   <= cfg_data[15:0];
          slpgm_pkg::REG_FADE_STEP:        fade_step    <= cfg_data[15:0];
          slpgm_pkg::REG_ATTACK_COEF:      attack_coef  <= cfg_data[15:0];
          slpgm_pkg::REG_RELEASE_COEF:     release_coef <= cfg_data[15:0];
          slpgm_pkg::REG_GAIN_PHASE_START: gain_phase   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_l <= left_in[slpgm_pkg::SAMPLE_BITS-1]
               ? slpgm_pkg::mag_t'(~left_in + 1'b1) : slpgm_pkg::mag_t'(left_in);
      mag_r <= right_in[slpgm_pkg::SAMPLE_BITS-1]
               ? slpgm_pkg::mag_t'(~right_in + 1'b1) : slpgm_pkg::mag_t'(right_in);
      neg_l <= left_in[slpgm_pkg::SAMPLE_BITS-1];
      neg_r <= right_in[slpgm_pkg::SAMPLE_BITS-1];
      res_l <= left_in;
      res_r <= right_in;
    end
    if (state == S_DONE && (!result_valid || result_ready)) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
    if (state == S_DIV) begin
      rem <= div_ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quo <= {quo[29:0], div_ge};
    end
    if (state == S_CALC && wb) begin
      case (op) inside
        OP_K: k <= prod[40:24];
        OP_PAN_SQ, OP_GAIN_SQ: begin
          t2  <= prod_q30[31:0];
          acc <= slpgm_pkg::sin_coef(3'd4);
        end
        [OP_PAN_P3:OP_PAN_P0], [OP_GAIN_P3:OP_GAIN_P0]: acc <= horner_sin;
        OP_PAN_S, OP_GAIN_S: begin
          acc <= (prod_q30 > {2'b0, slpgm_pkg::Q30_ONE}) ? slpgm_pkg::Q30_ONE
                                                         : prod_q30[31:0];
        end
        OP_PAN_D, OP_GAIN_D: acc <= prod[47:16];
        OP_PAN_K: begin
          lg <= pan_clamp(sin_neg ? pan_up : pan_dn);
          rg <= pan_clamp(sin_neg ? pan_dn : pan_up);
        end
        OP_GAIN_K: acc <= sin_neg ? pan_dn : pan_up;
        OP_TANH_Z: begin
          nexp <= prod[57:54];
          fexp <= prod[53:24];
          acc  <= slpgm_pkg::exp2_coef(3'd7);
        end
        [OP_EXP_6:OP_EXP_0]: begin
          acc <= horner_exp;
          if (op == OP_EXP_0) begin
            rem <= slpgm_pkg::Q30_ONE - e_val;
            dvs <= slpgm_pkg::Q30_ONE + e_val;
          end
        end
        OP_TH10: acc <= slpgm_pkg::Q30_ONE + 32'(prod >> 35);
        OP_GL:   lg  <= prod_q30[31:0];
        OP_GR:   rg  <= prod_q30[31:0];
        OP_OL:   res_l <= sat_out(neg_l, prod_q30);
        OP_OR:   res_r <= sat_out(neg_r, prod_q30);
        default: ;
      endcase
    end
  end

endmodule

@@ design/slpgm_checker.sv @@
// port-level checks for the stereo pan and gain modulator, bound to the top level
// uses slpgm_pkg and stereo_lfo_pan_gain_modulator_macros.svh
`include "stereo_lfo_pan_gain_modulator_macros.svh"

module slpgm_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_ready,
  input logic               result_valid,
  input logic               result_ready,
  input slpgm_pkg::sample_t left_out,
  input slpgm_pkg::sample_t right_out
);

  // one pair in flight: no transfer right after a transfer
  `SLPGM_ASSERT_NXT(a_one_in_flight, clk, rst, sample_valid && sample_ready, !sample_ready)

  // a result only appears after the block was busy
  `SLPGM_ASSERT_IMP(a_result_after_busy, clk, rst, $rose(result_valid), $past(!sample_ready))

  // stalled result holds
  `SLPGM_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready,
                    result_valid && $stable(left_out) && $stable(right_out))

  // reset empties the output and readies the input
  `SLPGM_ASSERT_RST(a_reset_state, clk, rst, !result_valid && sample_ready)

endmodule

bind stereo_lfo_pan_gain_modulator slpgm_checker u_slpgm_checker (.*);
